### hw/rtl/ctf_pkg.sv
package ctf_pkg;

  // Filter constants
  localparam int WEIGHT_DEN   = 1024;
  localparam int WEIGHT_RESET = 1004;
  localparam int TILT_SCALE   = 1000;

  // Field widths
  localparam int RATE_W  = 16;
  localparam int ACC_W   = 16;
  localparam int TIME_W  = 64;
  localparam int ANGLE_W = 32;
  localparam int WGT_W   = 11;

  // Sequencer step counts
  localparam int QUO_W     = 25;          // magnitude of accel*1000
  localparam int DIV_STEPS = QUO_W;
  localparam int MAC_STEPS = WGT_W;
  localparam int CNT_W     = 5;
  localparam int MIX_W     = 45;          // blend accumulator
  localparam int FRAC_W    = 10;          // log2 of WEIGHT_DEN

  typedef struct packed {
    logic signed [RATE_W-1:0] roll_rate;
    logic signed [RATE_W-1:0] pitch_rate;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;
    logic [TIME_W-1:0]        sample_time;
  } in_beat_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic                      fresh;
  } out_beat_t;

  // Datapath controls from the sequencer to each axis lane
  typedef struct packed {
    logic load;
    logic div_step;
    logic mac_init;
    logic mac_step;
  } axis_ctl_t;

endpackage

### hw/rtl/ctf_axis.sv
module ctf_axis
  import ctf_pkg::*;
(
  input  logic                      clk,
  input  axis_ctl_t                 ctl,
  input  logic signed [ANGLE_W-1:0] stored,
  input  logic signed [RATE_W-1:0]  rate,
  input  logic signed [ACC_W-1:0]   accel,
  input  logic [ACC_W-1:0]          az_mag,
  input  logic                      az_neg,
  input  logic [WGT_W-1:0]          w,
  input  logic [WGT_W-1:0]          cw,
  output logic signed [ANGLE_W-1:0] result
);

  logic signed [ANGLE_W:0]   gyro_r;
  logic                      neg_r;
  logic [ACC_W-1:0]          dvs_r;
  logic [ACC_W-1:0]          rem_r;
  logic [QUO_W-1:0]          quo_r;
  logic signed [MIX_W-1:0]   mcg_r;
  logic signed [MIX_W-1:0]   mca_r;
  logic [WGT_W-1:0]          mw_r;
  logic [WGT_W-1:0]          mcw_r;
  logic signed [MIX_W-1:0]   mix_r;

  logic signed [ANGLE_W:0]   gyro_nxt;
  logic signed [25:0]        a26;
  logic signed [25:0]        prod;
  logic [25:0]               prod_mag;
  logic [ACC_W:0]            rem_sh;
  logic                      fit;
  logic [MIX_W-1:0]          quo_ext;
  logic signed [MIX_W-1:0]   mix_add;
  logic signed [MIX_W-FRAC_W-1:0] mix_sh;
  logic signed [MIX_W-FRAC_W-1:0] mix_q;
  logic                      rnd;

  // Form the gyro sum and the scaled accel magnitude at load
  always_comb begin
    gyro_nxt = {stored[ANGLE_W-1], stored} + {{(ANGLE_W+1-RATE_W){rate[RATE_W-1]}}, rate};
    a26      = {{(26-ACC_W){accel[ACC_W-1]}}, accel};
    prod     = (a26 <<< 10) - (a26 <<< 4) - (a26 <<< 3);
    prod_mag = prod[25] ? 26'(-prod) : 26'(prod);
  end

  // Restoring divide, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_r, quo_r[QUO_W-1]};
    fit    = (rem_sh >= {1'b0, dvs_r});
  end

  // Shift-add blend, one weight bit a cycle on both products
  always_comb begin
    quo_ext = {{(MIX_W-QUO_W){1'b0}}, quo_r};
    mix_add = mix_r;
    if (mw_r[0]) begin
      mix_add = mix_add + mcg_r;
    end
    if (mcw_r[0]) begin
      mix_add = mix_add + mca_r;
    end
  end

  // Divide by 1024 toward zero, then saturate
  always_comb begin
    mix_sh = mix_r[MIX_W-1:FRAC_W];
    rnd    = mix_r[MIX_W-1] && (mix_r[FRAC_W-1:0] != '0);
    mix_q  = mix_sh + (MIX_W-FRAC_W)'(rnd);
    if (mix_q[MIX_W-FRAC_W-1:ANGLE_W-1] == '0 ||
        mix_q[MIX_W-FRAC_W-1:ANGLE_W-1] == '1) begin
      result = mix_q[ANGLE_W-1:0];
    end else if (mix_q[MIX_W-FRAC_W-1]) begin
      result = {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(ANGLE_W-1){1'b1}}};
    end
  end

  // Advance the lane datapath
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      gyro_r <= gyro_nxt;
      neg_r  <= accel[ACC_W-1] ^ az_neg;
      dvs_r  <= az_mag;
      rem_r  <= '0;
      quo_r  <= prod_mag[QUO_W-1:0];
      mw_r   <= w;
      mcw_r  <= cw;
    end else if (ctl.div_step) begin
      rem_r <= fit ? ACC_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[ACC_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fit};
    end else if (ctl.mac_init) begin
      mcg_r <= {{(MIX_W-ANGLE_W-1){gyro_r[ANGLE_W]}}, gyro_r};
      mca_r <= neg_r ? MIX_W'(-quo_ext) : quo_ext;
      mix_r <= '0;
    end else if (ctl.mac_step) begin
      mix_r <= mix_add;
      mcg_r <= mcg_r <<< 1;
      mca_r <= mca_r <<< 1;
      mw_r  <= mw_r >> 1;
      mcw_r <= mcw_r >> 1;
    end
  end

endmodule

### hw/rtl/complementary_tilt_filter.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   in_beat_t: rates, accel, sample_time
// out_     output     out_valid / out_stall out_beat_t: roll, pitch, fresh
// cfg_     input      cfg_valid / cfg_ready gyro_weight, 11 bits
//
// A new sample runs from accept to out_valid through the bit-serial divide of
// accel*1000 by az, a set-up step, the shift-add blend over the weight bits and
// a step to round, saturate and store; the next sample is accepted after that
// last step. A repeated sample skips straight to it and sends the stored angles.
// One sample is in work at a time; in_stall is high until the result is loaded.
// Synchronous active-low reset: angles and last time clear, weight goes to 1004.
// A held out_stall keeps the result beat; the next sample may be accepted meanwhile.
module complementary_tilt_filter
  import ctf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WGT_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_MINIT = 5'b00100,
    S_MAC   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [WGT_W-1:0]          w_r;
  logic [TIME_W-1:0]         last_time_r;
  logic signed [ANGLE_W-1:0] roll_r;
  logic signed [ANGLE_W-1:0] pitch_r;
  logic                      fresh_r;
  logic                      out_valid_r;
  out_beat_t                 out_r;

  logic                      in_acc;
  logic                      repeat_s;
  logic                      out_free;
  logic                      out_load;
  logic [WGT_W-1:0]          w_eff;
  logic [WGT_W-1:0]          cw;
  logic [ACC_W-1:0]          az_mag;
  logic signed [ANGLE_W-1:0] roll_new;
  logic signed [ANGLE_W-1:0] pitch_new;
  axis_ctl_t                 ctl;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign repeat_s  = (in_data.sample_time == last_time_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_FIN) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Clamp the weight and form the divisor magnitude, zero read as one
  always_comb begin
    w_eff = (w_r > WGT_W'(WEIGHT_DEN)) ? WGT_W'(WEIGHT_DEN) : w_r;
    cw    = WGT_W'(WEIGHT_DEN) - w_eff;
    if (in_data.accel_z == '0) begin
      az_mag = ACC_W'(1);
    end else if (in_data.accel_z[ACC_W-1]) begin
      az_mag = ACC_W'(-in_data.accel_z);
    end else begin
      az_mag = in_data.accel_z;
    end
  end

  // Sequence divide, blend and store
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ctl          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          if (repeat_s) begin
            state_nxt = S_FIN;
          end else begin
            ctl.load  = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MINIT;
        end
      end
      S_MINIT: begin
        ctl.mac_init = 1'b1;
        state_nxt    = S_MAC;
      end
      S_MAC: begin
        ctl.mac_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  ctf_axis u_roll (
    .clk    (clk),
    .ctl    (ctl),
    .stored (roll_r),
    .rate   (in_data.roll_rate),
    .accel  (in_data.accel_x),
    .az_mag (az_mag),
    .az_neg (in_data.accel_z[ACC_W-1]),
    .w      (w_eff),
    .cw     (cw),
    .result (roll_new)
  );

  ctf_axis u_pitch (
    .clk    (clk),
    .ctl    (ctl),
    .stored (pitch_r),
    .rate   (in_data.pitch_rate),
    .accel  (in_data.accel_y),
    .az_mag (az_mag),
    .az_neg (in_data.accel_z[ACC_W-1]),
    .w      (w_eff),
    .cw     (cw),
    .result (pitch_new)
  );

  // Hold control state, weight, timestamp and stored angles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      w_r         <= WGT_W'(WEIGHT_RESET);
      last_time_r <= '0;
      roll_r      <= '0;
      pitch_r     <= '0;
      fresh_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        w_r <= cfg_data;
      end
      if (in_acc) begin
        fresh_r <= !repeat_s;
        if (!repeat_s) begin
          last_time_r <= in_data.sample_time;
        end
      end
      if (out_load && fresh_r) begin
        roll_r  <= roll_new;
        pitch_r <= pitch_new;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.roll_angle  <= fresh_r ? roll_new : roll_r;
      out_r.pitch_angle <= fresh_r ? pitch_new : pitch_r;
      out_r.fresh       <= fresh_r;
    end
  end

  a_repeat_skips: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && repeat_s |=> state_r == S_FIN && !fresh_r)
    else $error("repeated sample did not skip to finish");

  a_time_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !repeat_s |=> last_time_r == $past(in_data.sample_time))
    else $error("last timestamp not captured");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result beat not loaded at finish");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DIV_STEPS - 1))
    else $error("step counter out of range");

endmodule
